@@ src/rbdf_pkg.sv @@
`default_nettype none

package rbdf_pkg;

   localparam int BUNDLE_W = 32;
   localparam int HASH_W   = 16;
   localparam int BYTE_W   = 8;
   localparam int LIMIT_W  = 8;
   localparam int CSR_W    = 32;
   localparam int PADDR_W  = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

   // register index taken from paddr[2]
   localparam logic REG_INSERT_LIMIT = 1'b0;

   localparam logic OP_CHECK  = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_MUL    = 9'b000000010,
      ST_SUB    = 9'b000000100,
      ST_READ   = 9'b000001000,
      ST_EVAL   = 9'b000010000,
      ST_WRITE2 = 9'b000100000,
      ST_COUNT  = 9'b001000000,
      ST_CLEAR  = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

endpackage

`default_nettype wire

@@ src/rbdf_channels.sv @@
`default_nettype none

interface rbdf_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [rbdf_pkg::BUNDLE_W-1:0] bundle_id;

   modport source (output valid, output op, output bundle_id, input ready);
   modport sink   (input valid, input op, input bundle_id, output ready);
endinterface

interface rbdf_rsp_if;
   logic valid;
   logic ready;
   logic seen;
   logic rotated;

   modport source (output valid, output seen, output rotated, input ready);
   modport sink   (input valid, input seen, input rotated, output ready);
endinterface

`default_nettype wire

@@ src/rotating_bloom_duplicate_filter.sv @@
`default_nettype none

// Duplicate filter over FILTER_COUNT bloom filters sharing one byte store of
// STORE_BYTES bytes held in a synchronous RAM (two read ports, one write port).
// The low and high halves of the bundle number are the two hashes; each is
// reduced modulo the bit count of one filter by a reciprocal multiply. After
// reset the block sweeps the whole store to zero, one byte a cycle, before the
// first item is accepted. A check makes one read-and-test pass per filter on
// the RAM, stopping at the first filter that holds both bits. An insert sets
// its two hash bits with one write, or with two when they fall in different
// bytes (one write port); an insert that rotates then sweeps the next filter
// clear. A finished result waits in an output register.
// insert_limit sits at byte address 0 of the register port.
module rotating_bloom_duplicate_filter #(
   parameter int STORE_BYTES  = 128,
   parameter int FILTER_COUNT = 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   rbdf_req_if.sink                           req,
   rbdf_rsp_if.source                         rsp,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [rbdf_pkg::PADDR_W-1:0]  csr_paddr,
   input  wire logic [rbdf_pkg::CSR_W-1:0]    csr_pwdata,
   output logic      [rbdf_pkg::CSR_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import rbdf_pkg::*;

   localparam int FBYTES   = STORE_BYTES / FILTER_COUNT;
   localparam int FBITS    = FBYTES * 8;
   localparam bit HAS_BITS = (FBYTES != 0);
   localparam int DIV      = HAS_BITS ? FBITS : 8;
   localparam int ADDR_W   = $clog2(STORE_BYTES);
   localparam int CNT_W    = $clog2(STORE_BYTES + 1);
   localparam int FI_W     = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;
   localparam int RECIP_W  = 30;
   localparam int PROD_W   = HASH_W + RECIP_W;
   localparam int QUOT_W   = PROD_W - 32;

   localparam logic [63:0] RECIP64 = ((64'd1 << 32) + 64'(DIV) - 64'd1) / 64'(DIV);
   localparam logic [RECIP_W-1:0] RECIP   = RECIP64[RECIP_W-1:0];
   localparam logic [HASH_W-1:0]  DIV_H   = HASH_W'(DIV);
   localparam logic [ADDR_W-1:0]  FBYTES_A = ADDR_W'(FBYTES);
   localparam logic [FI_W-1:0]    LAST_F  = FI_W'(FILTER_COUNT - 1);

   logic [BYTE_W-1:0] filter_mem [STORE_BYTES];

   state_type            state_ff, state_in;
   logic                 op_ff, op_in;
   logic [HASH_W-1:0]    h1_ff, h1_in, h2_ff, h2_in;
   logic [PROD_W-1:0]    p1_ff, p2_ff;
   logic [HASH_W-1:0]    r1_ff, r1_in, r2_ff, r2_in;
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic [FI_W-1:0]      filt_ff, filt_in;
   logic [FI_W-1:0]      cur_ff, cur_in;
   logic [ADDR_W-1:0]    cur_base_ff, cur_base_in;
   logic [LIMIT_W-1:0]   cnt_ff, cnt_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic                 seen_ff, seen_in;
   logic                 rot_ff, rot_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]     clr_left_ff, clr_left_in;
   logic                 clr_rot_ff, clr_rot_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_seen_ff, rsp_seen_in;
   logic                 rsp_rot_ff, rsp_rot_in;
   logic [BYTE_W-1:0]    rdata1_ff, rdata2_ff;

   logic [QUOT_W-1:0]    q1, q2;
   logic [31:0]          qd1, qd2;
   logic [HASH_W-1:0]    sum1, sum2;
   logic [ADDR_W-1:0]    rd_addr1, rd_addr2;
   logic [BYTE_W-1:0]    mask1, mask2;
   logic                 bit1, bit2;
   logic [LIMIT_W-1:0]   cnt_inc;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [BYTE_W-1:0]    wr_data;
   logic                 csr_write;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_INSERT_LIMIT) ?
                       {{(CSR_W - LIMIT_W){1'b0}}, limit_ff} : '0;

   assign req.ready   = (state_ff == ST_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.seen    = rsp_seen_ff;
   assign rsp.rotated = rsp_rot_ff;

   // quotient from the registered reciprocal products, then remainder
   assign q1  = p1_ff[PROD_W-1:32];
   assign q2  = p2_ff[PROD_W-1:32];
   assign qd1 = 32'(q1) * 32'(DIV_H);
   assign qd2 = 32'(q2) * 32'(DIV_H);

   assign sum1     = {3'b000, r1_ff[HASH_W-1:3]} + HASH_W'(base_ff);
   assign sum2     = {3'b000, r2_ff[HASH_W-1:3]} + HASH_W'(base_ff);
   assign rd_addr1 = sum1[ADDR_W-1:0];
   assign rd_addr2 = sum2[ADDR_W-1:0];
   assign mask1    = BYTE_W'(1) << r1_ff[2:0];
   assign mask2    = BYTE_W'(1) << r2_ff[2:0];
   assign bit1     = rdata1_ff[r1_ff[2:0]];
   assign bit2     = rdata2_ff[r2_ff[2:0]];
   assign cnt_inc  = cnt_ff + LIMIT_W'(1);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      h1_in        = h1_ff;
      h2_in        = h2_ff;
      r1_in        = r1_ff;
      r2_in        = r2_ff;
      base_in      = base_ff;
      filt_in      = filt_ff;
      cur_in       = cur_ff;
      cur_base_in  = cur_base_ff;
      cnt_in       = cnt_ff;
      limit_in     = limit_ff;
      seen_in      = seen_ff;
      rot_in       = rot_ff;
      clr_addr_in  = clr_addr_ff;
      clr_left_in  = clr_left_ff;
      clr_rot_in   = clr_rot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_seen_in  = rsp_seen_ff;
      rsp_rot_in   = rsp_rot_ff;
      wr_en        = 1'b0;
      wr_addr      = rd_addr1;
      wr_data      = rdata1_ff | mask1;

      if (csr_write && csr_paddr[2] == REG_INSERT_LIMIT) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               op_in    = req.op;
               h1_in    = req.bundle_id[HASH_W-1:0];
               h2_in    = req.bundle_id[BUNDLE_W-1:HASH_W];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_SUB;
         end
         ST_SUB: begin
            r1_in  = h1_ff - qd1[HASH_W-1:0];
            r2_in  = h2_ff - qd2[HASH_W-1:0];
            seen_in = (op_ff == OP_INSERT);
            rot_in  = 1'b0;
            if (op_ff == OP_INSERT) begin
               base_in = cur_base_ff;
            end else begin
               base_in = '0;
            end
            filt_in = '0;
            if (!HAS_BITS) begin
               state_in = (op_ff == OP_INSERT) ? ST_COUNT : ST_FINISH;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (op_ff == OP_INSERT) begin
               wr_en = 1'b1;
               if (rd_addr1 == rd_addr2) begin
                  // both bits in one byte: merge into a single write
                  wr_data  = rdata1_ff | mask1 | mask2;
                  state_in = ST_COUNT;
               end else begin
                  state_in = ST_WRITE2;
               end
            end else if (bit1 && bit2) begin
               seen_in  = 1'b1;
               state_in = ST_FINISH;
            end else if (filt_ff == LAST_F) begin
               state_in = ST_FINISH;
            end else begin
               filt_in  = filt_ff + FI_W'(1);
               base_in  = base_ff + FBYTES_A;
               state_in = ST_READ;
            end
         end
         ST_WRITE2: begin
            wr_en    = 1'b1;
            wr_addr  = rd_addr2;
            wr_data  = rdata2_ff | mask2;
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            if (cnt_inc > limit_ff) begin
               cnt_in = '0;
               rot_in = 1'b1;
               if (cur_ff == LAST_F) begin
                  cur_in      = '0;
                  cur_base_in = '0;
                  clr_addr_in = '0;
               end else begin
                  cur_in      = cur_ff + FI_W'(1);
                  cur_base_in = cur_base_ff + FBYTES_A;
                  clr_addr_in = cur_base_ff + FBYTES_A;
               end
               clr_left_in = CNT_W'(FBYTES);
               clr_rot_in  = 1'b1;
               state_in    = HAS_BITS ? ST_CLEAR : ST_FINISH;
            end else begin
               cnt_in   = cnt_inc;
               state_in = ST_FINISH;
            end
         end
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            clr_left_in = clr_left_ff - CNT_W'(1);
            if (clr_left_ff == CNT_W'(1)) begin
               state_in = clr_rot_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_seen_in  = seen_ff;
               rsp_rot_in   = rot_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_ff       <= '0;
         cur_base_ff  <= '0;
         cnt_ff       <= '0;
         limit_ff     <= LIMIT_RESET;
         clr_addr_ff  <= '0;
         clr_left_ff  <= CNT_W'(STORE_BYTES);
         clr_rot_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         cur_base_ff  <= cur_base_in;
         cnt_ff       <= cnt_in;
         limit_ff     <= limit_in;
         clr_addr_ff  <= clr_addr_in;
         clr_left_ff  <= clr_left_in;
         clr_rot_ff   <= clr_rot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      h1_ff       <= h1_in;
      h2_ff       <= h2_in;
      p1_ff       <= PROD_W'(h1_ff) * PROD_W'(RECIP);
      p2_ff       <= PROD_W'(h2_ff) * PROD_W'(RECIP);
      r1_ff       <= r1_in;
      r2_ff       <= r2_in;
      base_ff     <= base_in;
      filt_ff     <= filt_in;
      seen_ff     <= seen_in;
      rot_ff      <= rot_in;
      rsp_seen_ff <= rsp_seen_in;
      rsp_rot_ff  <= rsp_rot_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         filter_mem[wr_addr] <= wr_data;
      end
      rdata1_ff <= filter_mem[rd_addr1];
      rdata2_ff <= filter_mem[rd_addr2];
   end

   a_write_in_used_region: assert property (@(posedge clock) disable iff (reset)
      wr_en && state_ff != ST_CLEAR |-> 32'(wr_addr) < FILTER_COUNT * FBYTES)
      else $error("bit write outside the filters");

   a_rotate_zeroes_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && rot_ff |-> cnt_ff == '0)
      else $error("count not zeroed on rotation");

   a_base_tracks_filter: assert property (@(posedge clock) disable iff (reset)
      32'(cur_base_ff) == 32'(cur_ff) * FBYTES)
      else $error("current filter base out of step");

   a_rotated_implies_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rot_ff |-> rsp_seen_ff)
      else $error("rotating insert reported unseen");

   a_check_reads_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL && op_ff == OP_CHECK |-> !wr_en)
      else $error("check wrote the store");

endmodule

`default_nettype wire

@@ dv/rotating_bloom_duplicate_filter_tb.sv @@
module rotating_bloom_duplicate_filter_tb;
   import rbdf_pkg::*;

   localparam int STORE_BYTES    = 128;
   localparam int FILTER_COUNT   = 2;
   localparam int FILTER_BYTES   = STORE_BYTES / FILTER_COUNT;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int PHASE_ITEMS    = 100;
   localparam int RECENT_DEPTH   = 48;

   localparam logic [PADDR_W-1:0] ADDR_INSERT_LIMIT = {REG_INSERT_LIMIT, 2'b00};
   // index 1 has no register behind it
   localparam logic [PADDR_W-1:0] ADDR_UNMAPPED     = 3'd4;

   typedef struct packed {
      logic seen;
      logic rotated;
   } verdict_type;

   class bloom_scoreboard #(int FBYTES = 64, int FILTERS = 2);
      logic [BYTE_W-1:0]  bloom_bytes [FILTERS*FBYTES];
      logic [7:0]         insert_total;
      int unsigned        active_filter;
      logic [LIMIT_W-1:0] insert_limit;
      verdict_type        due_verdicts [$];
      int                 failures;

      function new();
         foreach (bloom_bytes[i]) bloom_bytes[i] = '0;
         insert_total  = '0;
         active_filter = 0;
         insert_limit  = LIMIT_RESET;
         failures      = 0;
      endfunction

      function bit bit_set(logic [HASH_W-1:0] hash, int unsigned filter);
         int unsigned pos;
         if (FBYTES == 0) return 1'b0;
         pos = hash % (FBYTES * 8);
         return bloom_bytes[filter*FBYTES + pos/8][pos%8];
      endfunction

      function void mark_bit(logic [HASH_W-1:0] hash, int unsigned filter);
         int unsigned pos;
         if (FBYTES == 0) return;
         pos = hash % (FBYTES * 8);
         bloom_bytes[filter*FBYTES + pos/8][pos%8] = 1'b1;
      endfunction

      function void write_register(int unsigned index, logic [CSR_W-1:0] value);
         if (index == REG_INSERT_LIMIT) insert_limit = value[LIMIT_W-1:0];
      endfunction

      function void record_request(logic op, logic [BUNDLE_W-1:0] num);
         verdict_type       v;
         logic [HASH_W-1:0] lo;
         logic [HASH_W-1:0] hi;
         v  = '0;
         lo = num[HASH_W-1:0];
         hi = num[BUNDLE_W-1:HASH_W];
         if (op == OP_CHECK) begin
            for (int f = 0; f < FILTERS; f++)
               if (bit_set(lo, f) && bit_set(hi, f)) v.seen = 1'b1;
         end else begin
            mark_bit(lo, active_filter);
            mark_bit(hi, active_filter);
            insert_total = insert_total + 8'd1;
            if (insert_total > insert_limit) begin
               // advance to the next filter and wipe it
               active_filter = (active_filter + 1) % FILTERS;
               for (int i = 0; i < FBYTES; i++) bloom_bytes[active_filter*FBYTES + i] = '0;
               insert_total = '0;
               v.rotated    = 1'b1;
            end
            v.seen = 1'b1;
         end
         due_verdicts.push_back(v);
      endfunction

      function void check_response(logic seen, logic rotated);
         verdict_type v;
         if (due_verdicts.size() == 0) begin
            $display("%0t: result with none expected, seen %0b rotated %0b",
                     $time, seen, rotated);
            failures++;
            return;
         end
         v = due_verdicts.pop_front();
         if (v.seen !== seen) begin
            $display("%0t: seen mismatch, expected %0b actual %0b", $time, v.seen, seen);
            failures++;
         end
         if (v.rotated !== rotated) begin
            $display("%0t: rotated mismatch, expected %0b actual %0b",
                     $time, v.rotated, rotated);
            failures++;
         end
      endfunction

      function int pending();
         return due_verdicts.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [PADDR_W-1:0] csr_paddr;
   logic [CSR_W-1:0]   csr_pwdata;
   logic [CSR_W-1:0]   csr_prdata;
   logic               csr_pready;

   rbdf_req_if req_ch();
   rbdf_rsp_if rsp_ch();

   rotating_bloom_duplicate_filter #(
      .STORE_BYTES (STORE_BYTES),
      .FILTER_COUNT(FILTER_COUNT)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   bloom_scoreboard #(.FBYTES(FILTER_BYTES), .FILTERS(FILTER_COUNT)) sb;

   int                  req_idle_pct;
   int                  rsp_idle_pct;
   bit                  hold_request;
   int                  hold_left;
   int                  quiet_cycles;
   logic [BUNDLE_W-1:0] recent_numbers [$];

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.seen, rsp_ch.rotated);
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_item(input logic op, input logic [BUNDLE_W-1:0] num);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.op        <= op;
      req_ch.bundle_id <= num;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.record_request(op, num);
      if (op == OP_INSERT) begin
         recent_numbers.push_back(num);
         if (recent_numbers.size() > RECENT_DEPTH) void'(recent_numbers.pop_front());
      end
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [PADDR_W-1:0] addr, input logic [CSR_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_register(32'(addr[PADDR_W-1:2]), data);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // drop valid and hold until every outstanding result is back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin
      logic [LIMIT_W-1:0]  phase_limits [8];
      logic [LIMIT_W-1:0]  lim;
      logic [BUNDLE_W-1:0] num;
      logic                op;

      clock            = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.op        = OP_CHECK;
      req_ch.bundle_id = '0;
      rsp_ch.ready     = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      req_idle_pct     = 30;
      rsp_idle_pct     = 51;
      hold_request     = 1'b0;
      hold_left        = 0;
      quiet_cycles     = 0;
      sb               = new();
      phase_limits     = '{8'd254, 8'd0, 8'd3, 8'd0, 8'd1, 8'd40, 8'd0, LIMIT_RESET};

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // a write past the only register must leave the limit alone
      write_csr(ADDR_UNMAPPED, '0);

      // empty store, extreme hashes, mixed halves
      send_item(OP_CHECK, 32'h0000_0000);
      send_item(OP_CHECK, 32'hFFFF_FFFF);
      send_item(OP_INSERT, 32'hFFFF_FFFF);
      send_item(OP_CHECK, 32'hFFFF_FFFF);
      send_item(OP_CHECK, 32'h01FF_01FF);
      send_item(OP_CHECK, 32'hFFFF_0000);
      send_item(OP_INSERT, 32'h0000_0000);
      send_item(OP_CHECK, 32'hFFFF_0000);
      send_item(OP_CHECK, 32'h0000_FFFF);
      send_item(OP_CHECK, 32'h1234_5678);
      drain_results();

      // limit zero: every insert rotates, so bits survive in one filter only
      write_csr(ADDR_INSERT_LIMIT, '0);
      send_item(OP_INSERT, 32'hAAAA_5555);
      send_item(OP_CHECK, 32'hAAAA_5555);
      send_item(OP_INSERT, 32'h5555_AAAA);
      send_item(OP_CHECK, 32'hAAAA_5555);
      send_item(OP_CHECK, 32'h5555_AAAA);
      send_item(OP_INSERT, 32'h8000_8000);
      send_item(OP_CHECK, 32'h5555_AAAA);
      drain_results();

      // only the low byte of the write is the limit
      write_csr(ADDR_INSERT_LIMIT, 32'hA5A5_A5FE);
      send_item(OP_INSERT, 32'h7FFF_8001);
      send_item(OP_CHECK, 32'h7FFF_8001);
      send_item(OP_CHECK, 32'h8001_7FFF);
      drain_results();

      for (int phase = 0; phase < 8; phase++) begin
         if (phase < 3) begin
            req_idle_pct = 30;
            rsp_idle_pct = 51;
         end else if (phase < 6) begin
            req_idle_pct = 51;
            rsp_idle_pct = 30;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         lim = phase_limits[phase];
         if (phase == 3 || phase == 6) lim = LIMIT_W'($urandom_range(0, 254));
         write_csr(ADDR_INSERT_LIMIT, {{(CSR_W-LIMIT_W){1'b0}}, lim});
         // stall the result side long enough to back up the input
         if (phase == 1) hold_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 20) num = $urandom;
            else num = ($urandom & 32'hFE00_FE00) | ($urandom & 32'h000F_000F);
            op = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_CHECK;
            if (op == OP_CHECK && recent_numbers.size() != 0 && $urandom_range(0, 1))
               num = recent_numbers[$urandom_range(0, recent_numbers.size() - 1)];
            send_item(op, num);
         end
         drain_results();
      end

      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
